// File: hdl/nts_pkg.sv
// nts_pkg: shared types, constants and helpers for the nearest-timestamp matcher.
// No dependencies; used by every module of the block.
package nts_pkg;

   localparam int QUEUE_DEPTH = 64;
   localparam int PTR_W       = $clog2(QUEUE_DEPTH);
   localparam int FILL_W      = $clog2(QUEUE_DEPTH + 1);
   localparam int TIME_W      = 48;
   localparam int DATA_W      = 32;
   localparam int PAIR_W      = 16;
   localparam int STATUS_W    = 3;
   localparam int CSR_IDX_W   = 8;

   localparam logic [PAIR_W-1:0] PAIRS_RESET = 16'd100;
   localparam logic [DATA_W-1:0] TOL_RESET   = 32'd10000;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_PAIRS_TO_ACQUIRE  = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SYNC_TOLERANCE_US = 8'd1;

   typedef enum logic [STATUS_W-1:0] {
      ST_BUFFERED = 3'd0,
      ST_MATCHED  = 3'd1,
      ST_NO_MATCH = 3'd2,
      ST_INVALID  = 3'd3,
      ST_ACQ_DONE = 3'd4,
      ST_IGNORED  = 3'd5,
      ST_DROPPED  = 3'd6
   } status_type;

   typedef struct packed {
      logic [PAIR_W-1:0] pairs_to_acquire;
      logic [DATA_W-1:0] sync_tolerance_us;
   } cfg_type;

   typedef struct packed {
      logic [TIME_W-1:0] time_us;
      logic [DATA_W-1:0] x;
      logic [DATA_W-1:0] y;
      logic [DATA_W-1:0] variance;
   } entry_type;

   function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] i);
      logic [PTR_W-1:0] r;
      if (i == PTR_W'(QUEUE_DEPTH - 1)) r = '0;
      else r = i + 1'b1;
      return r;
   endfunction

endpackage

// File: hdl/nts_csr_regs.sv
// nts_csr_regs: configuration register file (pair target, sync tolerance).
// Depends on nts_pkg.
module nts_csr_regs (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [nts_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [nts_pkg::DATA_W-1:0]        csr_wdata,
   output nts_pkg::cfg_type                  cfg
);

   nts_pkg::cfg_type cfg_ff;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pairs_to_acquire  <= nts_pkg::PAIRS_RESET;
         cfg_ff.sync_tolerance_us <= nts_pkg::TOL_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            nts_pkg::CSR_PAIRS_TO_ACQUIRE: begin
               cfg_ff.pairs_to_acquire <= csr_wdata[nts_pkg::PAIR_W-1:0];
            end
            nts_pkg::CSR_SYNC_TOLERANCE_US: begin
               cfg_ff.sync_tolerance_us <= csr_wdata;
            end
            default: begin
               // unknown index: write dropped
            end
         endcase
      end
   end

endmodule

// File: hdl/nts_queue_mem.sv
// nts_queue_mem: sample FIFO storage, one write and one registered read port.
// Depends on nts_pkg.
module nts_queue_mem (
   input  logic                          clock,
   input  logic                          wr_en,
   input  logic [nts_pkg::PTR_W-1:0]     wr_addr,
   input  nts_pkg::entry_type            wr_data,
   input  logic [nts_pkg::PTR_W-1:0]     rd_addr,
   output nts_pkg::entry_type            rd_data
);

   nts_pkg::entry_type mem_ff [nts_pkg::QUEUE_DEPTH];
   nts_pkg::entry_type rd_data_ff;

   assign rd_data = rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

endmodule

// File: hdl/nearest_timestamp_sample_matcher_core.sv
// nearest_timestamp_sample_matcher_core: top level of the timestamp matcher.
// Depends on nts_pkg, nts_csr_regs and nts_queue_mem.

// Timing: a dead-reckoning request, an invalid or ignored request, a
// reference request that finds the buffer empty and the request that ends
// acquisition are all handled without a scan; busy stays low and the result
// strobes on the next cycle, so such requests can be issued every cycle.
// A valid reference request with buffered samples raises busy and pops the
// buffer one entry per cycle (one read of the sample memory per cycle) until
// an entry lies within the tolerance or the buffer runs empty; 1 to 64
// entries are examined; the result strobes in the cycle busy falls. Results
// cannot be held off; rsp_strobe marks the single cycle in which each is
// valid. Configuration writes are always accepted (csr_ready tied high) and
// must only be issued while the block is idle.
module nearest_timestamp_sample_matcher_core (
   input  logic                                clock,
   input  logic                                reset,
   // request
   input  logic                                start,
   output logic                                busy,
   input  logic                                req_operation,
   input  logic [nts_pkg::TIME_W-1:0]          req_sample_time_us,
   input  logic signed [nts_pkg::DATA_W-1:0]   req_pos_x,
   input  logic signed [nts_pkg::DATA_W-1:0]   req_pos_y,
   input  logic [nts_pkg::DATA_W-1:0]          req_pos_variance,
   input  logic                                req_sample_valid,
   // result
   output logic                                rsp_strobe,
   output logic [nts_pkg::STATUS_W-1:0]        rsp_status,
   output logic [nts_pkg::PAIR_W-1:0]          rsp_pair_index,
   output logic [nts_pkg::TIME_W-1:0]          rsp_dead_time_us,
   output logic signed [nts_pkg::DATA_W-1:0]   rsp_dead_x,
   output logic signed [nts_pkg::DATA_W-1:0]   rsp_dead_y,
   output logic [nts_pkg::DATA_W-1:0]          rsp_dead_variance,
   output logic signed [nts_pkg::DATA_W-1:0]   rsp_ref_x,
   output logic signed [nts_pkg::DATA_W-1:0]   rsp_ref_y,
   output logic [nts_pkg::DATA_W-1:0]          rsp_ref_variance,
   // configuration
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [nts_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [nts_pkg::DATA_W-1:0]          csr_wdata
);

   typedef enum logic [1:0] {
      S_IDLE = 2'b01,
      S_SCAN = 2'b10
   } state_type;

   localparam int TW = nts_pkg::TIME_W;
   localparam int DW = nts_pkg::DATA_W;
   localparam int PW = nts_pkg::PTR_W;
   localparam int FW = nts_pkg::FILL_W;
   localparam int CW = nts_pkg::PAIR_W;

   nts_pkg::cfg_type cfg;

   state_type            state_ff, state_in;
   logic [PW-1:0]        head_ff, head_in;
   logic [PW-1:0]        tail_ff, tail_in;
   logic [FW-1:0]        fill_ff, fill_in;
   logic [CW-1:0]        pairs_count_ff, pairs_count_in;
   logic                 acquiring_ff, acquiring_in;

   // reference request held during a scan
   logic [TW-1:0]        ref_time_ff;
   logic [DW-1:0]        ref_x_ff, ref_y_ff, ref_var_ff;

   // result register
   logic                 rsp_strobe_ff, rsp_strobe_in;
   nts_pkg::status_type  rsp_status_ff, rsp_status_in;
   logic [CW-1:0]        rsp_pair_ff, rsp_pair_in;
   nts_pkg::entry_type   rsp_dead_ff, rsp_dead_in;
   logic [DW-1:0]        rsp_rx_ff, rsp_rx_in;
   logic [DW-1:0]        rsp_ry_ff, rsp_ry_in;
   logic [DW-1:0]        rsp_rv_ff, rsp_rv_in;

   logic                 accept;
   logic                 push;
   logic                 fifo_full;
   logic [PW-1:0]        rd_addr;
   nts_pkg::entry_type   wr_entry;
   nts_pkg::entry_type   head_entry;
   logic [TW-1:0]        time_gap;
   logic                 hit;
   logic                 last_entry;

   nts_csr_regs u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   assign busy      = (state_ff != S_IDLE);
   assign accept    = start && !busy;
   assign fifo_full = (fill_ff == FW'(nts_pkg::QUEUE_DEPTH));

   // push only on a valid dead-reckoning request with room left
   assign push = accept && acquiring_ff && !req_operation && req_sample_valid && !fifo_full;

   assign wr_entry.time_us  = req_sample_time_us;
   assign wr_entry.x        = req_pos_x;
   assign wr_entry.y        = req_pos_y;
   assign wr_entry.variance = req_pos_variance;

   // The read port runs one entry ahead: while idle it reads the head, so the
   // head entry is ready in the first scan cycle; while scanning it reads the
   // slot after the head. No push happens during a scan, so no forwarding.
   assign rd_addr = (state_ff == S_SCAN) ? nts_pkg::next_slot(head_ff) : head_ff;

   nts_queue_mem u_mem (
      .clock   (clock),
      .wr_en   (push),
      .wr_addr (tail_ff),
      .wr_data (wr_entry),
      .rd_addr (rd_addr),
      .rd_data (head_entry)
   );

   // |t - qt| and the tolerance test. The scan only continues while the head
   // entry's distance exceeds the tolerance, so the first entry within the
   // tolerance ends the scan and is returned, whether or not it is the nearest.
   assign time_gap = (ref_time_ff >= head_entry.time_us) ? (ref_time_ff - head_entry.time_us)
                                                         : (head_entry.time_us - ref_time_ff);
   assign hit        = (time_gap <= TW'(cfg.sync_tolerance_us));
   assign last_entry = hit || (fill_ff == FW'(1));

   always_comb begin
      state_in       = state_ff;
      head_in        = head_ff;
      tail_in        = tail_ff;
      fill_in        = fill_ff;
      pairs_count_in = pairs_count_ff;
      acquiring_in   = acquiring_ff;

      rsp_strobe_in  = 1'b0;
      rsp_status_in  = nts_pkg::ST_BUFFERED;
      rsp_pair_in    = '0;
      rsp_dead_in    = '0;
      rsp_rx_in      = '0;
      rsp_ry_in      = '0;
      rsp_rv_in      = '0;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               rsp_strobe_in = 1'b1;
               if (!acquiring_ff) begin
                  rsp_status_in = nts_pkg::ST_IGNORED;
               end else if (!req_operation) begin
                  if (!req_sample_valid) begin
                     rsp_status_in = nts_pkg::ST_INVALID;
                  end else if (fifo_full) begin
                     rsp_status_in = nts_pkg::ST_DROPPED;
                  end else begin
                     rsp_status_in = nts_pkg::ST_BUFFERED;
                     tail_in       = nts_pkg::next_slot(tail_ff);
                     fill_in       = fill_ff + 1'b1;
                  end
               end else if (!(cfg.pairs_to_acquire > pairs_count_ff)) begin
                  // target reached: this reference request closes acquisition
                  acquiring_in  = 1'b0;
                  rsp_status_in = nts_pkg::ST_ACQ_DONE;
               end else if (!req_sample_valid) begin
                  rsp_status_in = nts_pkg::ST_INVALID;
               end else if (fill_ff == '0) begin
                  rsp_status_in = nts_pkg::ST_NO_MATCH;
               end else begin
                  // result comes at the end of the scan
                  rsp_strobe_in = 1'b0;
                  state_in      = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            head_in = nts_pkg::next_slot(head_ff);
            fill_in = fill_ff - 1'b1;
            if (last_entry) begin
               state_in      = S_IDLE;
               rsp_strobe_in = 1'b1;
               if (hit) begin
                  rsp_status_in  = nts_pkg::ST_MATCHED;
                  rsp_pair_in    = pairs_count_ff;
                  rsp_dead_in    = head_entry;
                  rsp_rx_in      = ref_x_ff;
                  rsp_ry_in      = ref_y_ff;
                  rsp_rv_in      = ref_var_ff;
                  pairs_count_in = pairs_count_ff + 1'b1;
               end else begin
                  rsp_status_in = nts_pkg::ST_NO_MATCH;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         head_ff        <= '0;
         tail_ff        <= '0;
         fill_ff        <= '0;
         pairs_count_ff <= '0;
         acquiring_ff   <= 1'b1;
         rsp_strobe_ff  <= 1'b0;
      end else begin
         state_ff       <= state_in;
         head_ff        <= head_in;
         tail_ff        <= tail_in;
         fill_ff        <= fill_in;
         pairs_count_ff <= pairs_count_in;
         acquiring_ff   <= acquiring_in;
         rsp_strobe_ff  <= rsp_strobe_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         ref_time_ff <= req_sample_time_us;
         ref_x_ff    <= req_pos_x;
         ref_y_ff    <= req_pos_y;
         ref_var_ff  <= req_pos_variance;
      end
      rsp_status_ff <= rsp_status_in;
      rsp_pair_ff   <= rsp_pair_in;
      rsp_dead_ff   <= rsp_dead_in;
      rsp_rx_ff     <= rsp_rx_in;
      rsp_ry_ff     <= rsp_ry_in;
      rsp_rv_ff     <= rsp_rv_in;
   end

   assign rsp_strobe        = rsp_strobe_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_pair_index    = rsp_pair_ff;
   assign rsp_dead_time_us  = rsp_dead_ff.time_us;
   assign rsp_dead_x        = rsp_dead_ff.x;
   assign rsp_dead_y        = rsp_dead_ff.y;
   assign rsp_dead_variance = rsp_dead_ff.variance;
   assign rsp_ref_x         = rsp_rx_ff;
   assign rsp_ref_y         = rsp_ry_ff;
   assign rsp_ref_variance  = rsp_rv_ff;

endmodule

// File: hdl/nts_checker.sv
// nts_checker: port-level assertions for the timestamp matcher, bound to the top.
// Depends on nts_pkg and nearest_timestamp_sample_matcher_core.
module nts_checker (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic                                busy,
   input  logic                                rsp_strobe,
   input  logic [nts_pkg::STATUS_W-1:0]        rsp_status,
   input  logic [nts_pkg::PAIR_W-1:0]          rsp_pair_index,
   input  logic [nts_pkg::TIME_W-1:0]          rsp_dead_time_us,
   input  logic [nts_pkg::DATA_W-1:0]          rsp_dead_x,
   input  logic [nts_pkg::DATA_W-1:0]          rsp_ref_x
);

   // every accepted request either answers next cycle or starts a scan
   a_accept_answers: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (rsp_strobe || busy))
      else $error("accepted request produced neither result nor scan");

   // a result never shows while a scan is still running
   a_no_rsp_when_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("result strobed while busy");

   // busy only rises after an accepted request
   a_busy_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(busy) |-> $past(start))
      else $error("busy rose without a request");

   // pair index, dead time, dead x and ref x are zero unless the result is a match
   a_zero_unmatched: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_status != nts_pkg::ST_MATCHED) |->
         (rsp_pair_index == '0 && rsp_dead_time_us == '0 &&
          rsp_dead_x == '0 && rsp_ref_x == '0))
      else $error("non-match result carries payload");

endmodule

bind nearest_timestamp_sample_matcher_core nts_checker u_nts_checker (
   .clock            (clock),
   .reset            (reset),
   .start            (start),
   .busy             (busy),
   .rsp_strobe       (rsp_strobe),
   .rsp_status       (rsp_status),
   .rsp_pair_index   (rsp_pair_index),
   .rsp_dead_time_us (rsp_dead_time_us),
   .rsp_dead_x       (rsp_dead_x),
   .rsp_ref_x        (rsp_ref_x)
);
